// ===== design/wait_queue_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Wait queue engine assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef WAIT_QUEUE_ENGINE_UNIT_ASSERT_SVH
`define WAIT_QUEUE_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define WQE_ASSERT_NOW(lbl, ck, rs_n, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs_n) (ante) |-> (cons)) \
    else $error("wait queue engine check failed");
// The consequent must hold in the cycle after the antecedent.
`define WQE_ASSERT_NEXT(lbl, ck, rs_n, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs_n) (ante) |=> (cons)) \
    else $error("wait queue engine check failed");
`else
`define WQE_ASSERT_NOW(lbl, ck, rs_n, ante, cons)
`define WQE_ASSERT_NEXT(lbl, ck, rs_n, ante, cons)
`endif
`endif

// ===== design/wqe_pkg.sv =====
// ----------------------------------------------------------------------------
// Wait queue engine package
// Field widths, parameter defaults, command and status codes, shared types.
// ----------------------------------------------------------------------------
package wqe_pkg;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int TASK_W   = 16;
  localparam int STATUS_W = 2;

  // Number of slots the slot field can name.
  localparam int SLOT_SPACE = 1 << SLOT_W;

  localparam int SLOTS_DEF      = 64;
  localparam int TASK_BITS_DEF  = 16;
  localparam int WAKE_LIMIT_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_WAKE_ONE,
    CMD_WAKE_ALL
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_ALREADY_QUEUED,
    STAT_NOT_QUEUED,
    STAT_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_UNLINK,
    S_WALK
  } state_t;

  // Write strobes toward the slot tables.
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic task_we;
    logic mark_set;
    logic mark_clr;
  } tbl_ctl_t;

endpackage

// ===== design/wqe_table.sv =====
// ----------------------------------------------------------------------------
// Wait queue slot tables
// Next link, previous link and task id memories with one shared read address
// and registered read data, plus the on-queue marks kept in flops.
// ----------------------------------------------------------------------------
module wqe_table #(
  parameter int ND = wqe_pkg::SLOTS_DEF,
  parameter int IW = $clog2(wqe_pkg::SLOTS_DEF),
  parameter int LW = $clog2(wqe_pkg::SLOTS_DEF + 1),
  parameter int TW = wqe_pkg::TASK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wqe_pkg::tbl_ctl_t   ctl,
  input  logic [IW-1:0]       mark_addr,
  output logic                mark_q,
  input  logic [IW-1:0]       rd_addr,
  output logic [LW-1:0]       rd_next,
  output logic [LW-1:0]       rd_prev,
  output logic [TW-1:0]       rd_task,
  input  logic [IW-1:0]       next_waddr,
  input  logic [LW-1:0]       next_wdata,
  input  logic [IW-1:0]       prev_waddr,
  input  logic [LW-1:0]       prev_wdata,
  input  logic [IW-1:0]       task_waddr,
  input  logic [TW-1:0]       task_wdata
);

  logic [LW-1:0] next_mem_r [ND];
  logic [LW-1:0] prev_mem_r [ND];
  logic [TW-1:0] task_mem_r [ND];
  logic [ND-1:0] mark_r;
  logic [LW-1:0] rd_next_r;
  logic [LW-1:0] rd_prev_r;
  logic [TW-1:0] rd_task_r;

  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem_r[next_waddr] <= next_wdata;
    end
    if (ctl.prev_we) begin
      prev_mem_r[prev_waddr] <= prev_wdata;
    end
    if (ctl.task_we) begin
      task_mem_r[task_waddr] <= task_wdata;
    end
    rd_next_r <= next_mem_r[rd_addr];
    rd_prev_r <= prev_mem_r[rd_addr];
    rd_task_r <= task_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
    end else if (ctl.mark_set) begin
      mark_r[mark_addr] <= 1'b1;
    end else if (ctl.mark_clr) begin
      mark_r[mark_addr] <= 1'b0;
    end
  end

  assign mark_q  = mark_r[mark_addr];
  assign rd_next = rd_next_r;
  assign rd_prev = rd_prev_r;
  assign rd_task = rd_task_r;

endmodule

// ===== design/wait_queue_engine_unit.sv =====
// Add and rejected commands pass from the capture registers through the decide state
// to the result register; remove and non-empty wakes add the registered table read.
// Wake all then gives one result per cycle while the output side keeps taking them.
// A new input beat is taken only once the last result is registered, so commands do
// not overlap: an add passes through the capture in idle and the decide state.
// Reset clears the on-queue marks and the head, with no clearing pass.
// ----------------------------------------------------------------------------
// Wait queue engine
// Doubly linked wait queue held in slot tables, newest entry at the head.
// ----------------------------------------------------------------------------
`include "wait_queue_engine_unit_assert.svh"

module wait_queue_engine_unit #(
  parameter int SLOTS      = wqe_pkg::SLOTS_DEF,
  parameter int TASK_BITS  = wqe_pkg::TASK_BITS_DEF,
  parameter int WAKE_LIMIT = wqe_pkg::WAKE_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wqe_pkg::CMD_W-1:0]      in_command,
  input  logic [wqe_pkg::SLOT_W-1:0]     in_entry_slot,
  input  logic [wqe_pkg::TASK_W-1:0]     in_task_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wqe_pkg::TASK_W-1:0]     out_woken_task,
  output logic                           out_wake_valid,
  output logic                           out_last_result,
  output logic [wqe_pkg::STATUS_W-1:0]   out_status
);

  // Only the slots the slot field can reach need storage.
  localparam int ND = (SLOTS < wqe_pkg::SLOT_SPACE) ? SLOTS : wqe_pkg::SLOT_SPACE;
  localparam int IW = $clog2(ND);
  // Links carry one extra code, ND, meaning no entry.
  localparam int LW = $clog2(ND + 1);
  localparam int TW = (TASK_BITS < wqe_pkg::TASK_W) ? TASK_BITS : wqe_pkg::TASK_W;
  localparam int CW = (WAKE_LIMIT > 1) ? $clog2(WAKE_LIMIT) : 1;

  localparam logic [LW-1:0]               NO_LINK   = LW'(ND);
  localparam logic [wqe_pkg::SLOT_W:0]    SLOT_LIM  = (wqe_pkg::SLOT_W + 1)'(ND);
  localparam logic [CW-1:0]               LAST_CNT  = CW'(WAKE_LIMIT - 1);

  wqe_pkg::state_t  state_r, state_nxt;
  wqe_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [wqe_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [TW-1:0]    task_r, task_nxt;
  logic [LW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  logic                          out_valid_r;
  logic [wqe_pkg::TASK_W-1:0]    out_task_r;
  logic                          out_wvalid_r;
  logic                          out_last_r;
  wqe_pkg::status_t              out_status_r;

  logic                          emit;
  logic [wqe_pkg::TASK_W-1:0]    e_task;
  logic                          e_wvalid;
  logic                          e_last;
  wqe_pkg::status_t              e_status;

  wqe_pkg::tbl_ctl_t ctl;
  logic [IW-1:0] slot_idx;
  logic [IW-1:0] head_idx;
  logic          slot_ok;
  logic          head_none;
  logic          mark_q;
  logic [IW-1:0] rd_addr;
  logic [LW-1:0] rd_next;
  logic [LW-1:0] rd_prev;
  logic [TW-1:0] rd_task;
  logic [IW-1:0] next_waddr;
  logic [LW-1:0] next_wdata;
  logic [IW-1:0] prev_waddr;
  logic [LW-1:0] prev_wdata;
  logic [IW-1:0] task_waddr;
  logic [TW-1:0] task_wdata;
  logic          out_free;
  logic          walk_last;

  // A slot index is meaningful only below the number of stored slots.
  assign slot_ok   = {1'b0, slot_r} < SLOT_LIM;
  assign slot_idx  = slot_r[IW-1:0];
  assign head_idx  = head_r[IW-1:0];
  assign head_none = (head_r == NO_LINK);

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // The walk ends at the tail, at the wake limit, or at once for wake one.
  assign walk_last = (cmd_r == wqe_pkg::CMD_WAKE_ONE) || (rd_next == NO_LINK) ||
                     (count_r == LAST_CNT);

  assign in_ready = (state_r == wqe_pkg::S_IDLE);

  wqe_table #(
    .ND (ND),
    .IW (IW),
    .LW (LW),
    .TW (TW)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .mark_addr  (slot_idx),
    .mark_q     (mark_q),
    .rd_addr    (rd_addr),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .rd_task    (rd_task),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .task_waddr (task_waddr),
    .task_wdata (task_wdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wqe_pkg::S_IDLE;
      head_r  <= NO_LINK;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    slot_r  <= slot_nxt;
    task_r  <= task_nxt;
    cur_r   <= cur_nxt;
    count_r <= count_nxt;
  end

  // Sequencer. Every link and task read goes through the one shared read port;
  // writes for a command are committed together with its result beat.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    slot_nxt   = slot_r;
    task_nxt   = task_r;
    head_nxt   = head_r;
    cur_nxt    = cur_r;
    count_nxt  = count_r;
    ctl        = '0;
    rd_addr    = cur_r;
    next_waddr = slot_idx;
    next_wdata = head_r;
    prev_waddr = head_idx;
    prev_wdata = LW'(slot_idx);
    task_waddr = slot_idx;
    task_wdata = task_r;
    emit       = 1'b0;
    e_task     = '0;
    e_wvalid   = 1'b0;
    e_last     = 1'b1;
    e_status   = wqe_pkg::STAT_OK;

    case (state_r)
      wqe_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = wqe_pkg::cmd_t'(in_command);
          slot_nxt  = in_entry_slot;
          task_nxt  = in_task_id[TW-1:0];
          state_nxt = wqe_pkg::S_DECIDE;
        end
      end

      wqe_pkg::S_DECIDE: begin
        case (cmd_r)
          wqe_pkg::CMD_ADD: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = wqe_pkg::S_IDLE;
              if (!slot_ok) begin
                e_status = wqe_pkg::STAT_NOT_QUEUED;
              end else if (mark_q) begin
                e_status = wqe_pkg::STAT_ALREADY_QUEUED;
              end else begin
                // New entry at the head; the old head points back to it.
                ctl.task_we  = 1'b1;
                ctl.next_we  = 1'b1;
                ctl.prev_we  = !head_none;
                ctl.mark_set = 1'b1;
                head_nxt     = LW'(slot_idx);
              end
            end
          end

          wqe_pkg::CMD_REMOVE: begin
            rd_addr = slot_idx;
            if (!slot_ok || !mark_q) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = wqe_pkg::STAT_NOT_QUEUED;
                state_nxt = wqe_pkg::S_IDLE;
              end
            end else begin
              state_nxt = wqe_pkg::S_UNLINK;
            end
          end

          default: begin
            // Both wake commands start at the head.
            rd_addr = head_idx;
            if (head_none) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = wqe_pkg::STAT_EMPTY;
                state_nxt = wqe_pkg::S_IDLE;
              end
            end else begin
              cur_nxt   = head_idx;
              count_nxt = '0;
              state_nxt = wqe_pkg::S_WALK;
            end
          end
        endcase
      end

      wqe_pkg::S_UNLINK: begin
        // Keep reading the removed slot so its links stay on the read port.
        rd_addr    = slot_idx;
        next_waddr = rd_prev[IW-1:0];
        next_wdata = rd_next;
        prev_waddr = rd_next[IW-1:0];
        prev_wdata = rd_prev;
        if (out_free) begin
          emit         = 1'b1;
          ctl.mark_clr = 1'b1;
          state_nxt    = wqe_pkg::S_IDLE;
          // The head has no predecessor: its successor becomes the head.
          if (head_r == LW'(slot_idx)) begin
            head_nxt = rd_next;
          end else begin
            ctl.next_we = 1'b1;
          end
          ctl.prev_we = (rd_next != NO_LINK);
        end
      end

      wqe_pkg::S_WALK: begin
        rd_addr = cur_r;
        if (out_free) begin
          emit     = 1'b1;
          e_task   = wqe_pkg::TASK_W'(rd_task);
          e_wvalid = 1'b1;
          e_last   = walk_last;
          if (walk_last) begin
            state_nxt = wqe_pkg::S_IDLE;
          end else begin
            // Follow the link straight away so the next entry is read now.
            cur_nxt   = rd_next[IW-1:0];
            rd_addr   = rd_next[IW-1:0];
            count_nxt = count_r + CW'(1);
          end
        end
      end

      default: begin
        state_nxt = wqe_pkg::S_IDLE;
      end
    endcase
  end

  // Result register: it parts the sequencer from the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_task_r   <= e_task;
      out_wvalid_r <= e_wvalid;
      out_last_r   <= e_last;
      out_status_r <= e_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_woken_task  = out_task_r;
  assign out_wake_valid  = out_wvalid_r;
  assign out_last_result = out_last_r;
  assign out_status      = out_status_r;

  `WQE_ASSERT_NEXT(a_accept_decide, clk, rst_n, in_valid && in_ready, state_r == wqe_pkg::S_DECIDE)
  `WQE_ASSERT_NOW(a_emit_room, clk, rst_n, emit, out_free)
  `WQE_ASSERT_NOW(a_walk_bound, clk, rst_n, state_r == wqe_pkg::S_WALK, count_r <= LAST_CNT)
  `WQE_ASSERT_NEXT(a_wake_walk, clk, rst_n,
                   state_r == wqe_pkg::S_DECIDE && !head_none &&
                   (cmd_r == wqe_pkg::CMD_WAKE_ONE || cmd_r == wqe_pkg::CMD_WAKE_ALL),
                   state_r == wqe_pkg::S_WALK && count_r == '0)

endmodule

// ===== tb/sv/tb_wait_queue_engine_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wait queue engine testbench
// Drives add, remove and wake commands into the engine and checks every reply
// beat against a scoreboard that keeps its own copy of the linked wait queue.
// ----------------------------------------------------------------------------
module tb_wait_queue_engine_unit;

  localparam int CMD_W          = wqe_pkg::CMD_W;
  localparam int SLOT_W         = wqe_pkg::SLOT_W;
  localparam int TASK_W         = wqe_pkg::TASK_W;
  localparam int STATUS_W       = wqe_pkg::STATUS_W;
  localparam int SLOTS_DEF      = wqe_pkg::SLOTS_DEF;
  localparam int WAKE_LIMIT_DEF = wqe_pkg::WAKE_LIMIT_DEF;

  // The head and the links use one extra bit so that they can say "no entry".
  localparam logic [SLOT_W:0] NO_ENTRY = (SLOT_W + 1)'(SLOTS_DEF);
  // Length of the long receiver hold-off that backs the engine up.
  localparam int STALL_CYCLES = 300;
  // Quiet cycles after the last expected reply, enough to expose a stray beat.
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [TASK_W-1:0] woken_task;
    logic              wake_valid;
    logic              last_result;
    wqe_pkg::status_t  status;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = '0;
  logic [SLOT_W-1:0]   in_entry_slot = '0;
  logic [TASK_W-1:0]   in_task_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [TASK_W-1:0]   out_woken_task;
  logic                out_wake_valid;
  logic                out_last_result;
  logic [STATUS_W-1:0] out_status;

  // Idle rates in percent for each side, changed between traffic phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Hold-off requests from the stimulus and the ones the receiver has served.
  int          stall_req = 0;
  int          stall_ack = 0;
  int          stall_left = 0;
  int          errors = 0;

  // Scoreboard copy of the wait queue. The older link points toward the tail,
  // the newer link toward the head.
  logic [SLOT_W:0]   head_slot;
  logic [SLOT_W:0]   older_link [SLOTS_DEF];
  logic [SLOT_W:0]   newer_link [SLOTS_DEF];
  logic              linked_flag [SLOTS_DEF];
  logic [TASK_W-1:0] waiter_task [SLOTS_DEF];

  // Reply beats that the engine still owes, oldest first.
  reply_t queue_replies[$];

  wait_queue_engine_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_entry_slot   (in_entry_slot),
    .in_task_id      (in_task_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_woken_task  (out_woken_task),
    .out_wake_valid  (out_wake_valid),
    .out_last_result (out_last_result),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SLOT_W-1:0] rand_slot();
    return SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
  endfunction

  function automatic logic [TASK_W-1:0] rand_task();
    return TASK_W'($urandom_range(0, 65535));
  endfunction

  // Applies one accepted command to the scoreboard queue and appends the reply
  // beats that the engine must produce for it.
  function automatic void apply_queue_cmd(wqe_pkg::cmd_t op, logic [SLOT_W-1:0] slot,
                                          logic [TASK_W-1:0] tid);
    reply_t          r;
    logic [SLOT_W:0] p;
    logic [SLOT_W:0] n;
    logic [SLOT_W:0] cur;
    int              count;
    r.woken_task  = '0;
    r.wake_valid  = 1'b0;
    r.last_result = 1'b1;
    r.status      = wqe_pkg::STAT_OK;
    case (op)
      wqe_pkg::CMD_ADD: begin
        // Adding a slot that is already linked leaves the list alone.
        if (linked_flag[slot]) begin
          r.status = wqe_pkg::STAT_ALREADY_QUEUED;
        end else begin
          waiter_task[slot] = tid;
          newer_link[slot]  = NO_ENTRY;
          older_link[slot]  = head_slot;
          if (head_slot != NO_ENTRY) newer_link[head_slot[SLOT_W-1:0]] = {1'b0, slot};
          head_slot         = {1'b0, slot};
          linked_flag[slot] = 1'b1;
        end
        queue_replies.push_back(r);
      end
      wqe_pkg::CMD_REMOVE: begin
        if (!linked_flag[slot]) begin
          r.status = wqe_pkg::STAT_NOT_QUEUED;
        end else begin
          p = newer_link[slot];
          n = older_link[slot];
          if (p != NO_ENTRY) older_link[p[SLOT_W-1:0]] = n;
          else head_slot = n;
          if (n != NO_ENTRY) newer_link[n[SLOT_W-1:0]] = p;
          newer_link[slot]  = NO_ENTRY;
          older_link[slot]  = NO_ENTRY;
          linked_flag[slot] = 1'b0;
        end
        queue_replies.push_back(r);
      end
      default: begin
        if (head_slot == NO_ENTRY) begin
          // Either wake on an empty queue gives a single empty reply.
          r.status = wqe_pkg::STAT_EMPTY;
          queue_replies.push_back(r);
        end else if (op == wqe_pkg::CMD_WAKE_ONE) begin
          r.woken_task = waiter_task[head_slot[SLOT_W-1:0]];
          r.wake_valid = 1'b1;
          queue_replies.push_back(r);
        end else begin
          // Wake all reports from the head toward the tail and stops at the
          // wake limit; the final beat is marked either way.
          cur   = head_slot;
          count = 0;
          while (cur != NO_ENTRY && count < WAKE_LIMIT_DEF) begin
            r.woken_task  = waiter_task[cur[SLOT_W-1:0]];
            r.wake_valid  = 1'b1;
            r.last_result = (older_link[cur[SLOT_W-1:0]] == NO_ENTRY) ||
                            (count + 1 >= WAKE_LIMIT_DEF);
            queue_replies.push_back(r);
            count++;
            cur = older_link[cur[SLOT_W-1:0]];
          end
        end
      end
    endcase
  endfunction

  // Returns a slot whose on-queue mark matches, starting the search at a random
  // place, or NO_ENTRY when there is none.
  function automatic logic [SLOT_W:0] find_slot(logic want_queued);
    int              base;
    logic [SLOT_W:0] found;
    found = NO_ENTRY;
    base  = $urandom_range(0, SLOTS_DEF - 1);
    for (int k = 0; k < SLOTS_DEF; k++) begin
      if (found == NO_ENTRY && linked_flag[(base + k) % SLOTS_DEF] == want_queued) begin
        found = (SLOT_W + 1)'((base + k) % SLOTS_DEF);
      end
    end
    return found;
  endfunction

  // Offers one command beat and returns at the edge where it is accepted. Valid
  // is only dropped for an idle gap, so back-to-back beats keep it high.
  task automatic send_cmd(wqe_pkg::cmd_t op, logic [SLOT_W-1:0] slot,
                          logic [TASK_W-1:0] tid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= op;
    in_entry_slot <= slot;
    in_task_id    <= tid;
    do @(posedge clk); while (!in_ready);
    apply_queue_cmd(op, slot, tid);
  endtask

  // Compares one accepted reply beat with the oldest one still owed.
  function automatic void check_reply();
    reply_t exp;
    if (queue_replies.size() == 0) begin
      $error("unexpected reply beat: task %0d wake %0d last %0d status %0d",
             out_woken_task, out_wake_valid, out_last_result, out_status);
      errors++;
      return;
    end
    exp = queue_replies.pop_front();
    if (out_woken_task !== exp.woken_task) begin
      $error("woken_task: expected %0d, got %0d", exp.woken_task, out_woken_task);
      errors++;
    end
    if (out_wake_valid !== exp.wake_valid) begin
      $error("wake_valid: expected %0d, got %0d", exp.wake_valid, out_wake_valid);
      errors++;
    end
    if (out_last_result !== exp.last_result) begin
      $error("last_result: expected %0d, got %0d", exp.last_result, out_last_result);
      errors++;
    end
    if (out_status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, out_status);
      errors++;
    end
  endfunction

  // Receiver side. Every accepted reply beat is checked here. Ready is drawn at
  // random from the current idle rate, except during a hold-off, which this
  // process counts down on its own while the stimulus keeps offering beats.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_reply();
    if (stall_req != stall_ack) begin
      stall_ack  <= stall_req;
      stall_left <= STALL_CYCLES;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Walks through the corner cases on a short queue: wakes on an empty queue,
  // removal of a slot that is not linked, a second add of a linked slot, the
  // extreme slot indexes and task ids (task id zero among them), and removal
  // from the head, the middle and the tail.
  task automatic test_directed_basics();
    send_cmd(wqe_pkg::CMD_WAKE_ONE, 6'h3f, 16'hffff);
    send_cmd(wqe_pkg::CMD_WAKE_ALL, 6'h00, 16'h0000);
    send_cmd(wqe_pkg::CMD_REMOVE,   6'h00, 16'h0000);
    send_cmd(wqe_pkg::CMD_ADD,      6'h00, 16'h0000);
    send_cmd(wqe_pkg::CMD_ADD,      6'h3f, 16'hffff);
    send_cmd(wqe_pkg::CMD_ADD,      6'h3f, 16'h1234);
    send_cmd(wqe_pkg::CMD_WAKE_ONE, 6'h15, 16'h5555);
    send_cmd(wqe_pkg::CMD_WAKE_ALL, 6'h2a, 16'haaaa);
    send_cmd(wqe_pkg::CMD_REMOVE,   6'h00, 16'hffff);
    send_cmd(wqe_pkg::CMD_REMOVE,   6'h3f, 16'h0000);
    send_cmd(wqe_pkg::CMD_WAKE_ALL, 6'h3f, 16'hffff);
    send_cmd(wqe_pkg::CMD_ADD,      6'h05, 16'haaaa);
    send_cmd(wqe_pkg::CMD_ADD,      6'h15, 16'h5555);
    send_cmd(wqe_pkg::CMD_ADD,      6'h2a, 16'h0f0f);
    send_cmd(wqe_pkg::CMD_REMOVE,   6'h15, 16'h0000);
    send_cmd(wqe_pkg::CMD_WAKE_ALL, 6'h00, 16'h0000);
    send_cmd(wqe_pkg::CMD_REMOVE,   6'h2a, 16'h0000);
    send_cmd(wqe_pkg::CMD_WAKE_ONE, 6'h00, 16'h0000);
    send_cmd(wqe_pkg::CMD_REMOVE,   6'h05, 16'h0000);
    send_cmd(wqe_pkg::CMD_REMOVE,   6'h05, 16'h0000);
    send_cmd(wqe_pkg::CMD_WAKE_ONE, 6'h2a, 16'h0f0f);
  endtask

  // Mostly well-formed traffic: adds go to free slots and removes to linked
  // ones, with a small share of repeated adds and stray removes as noise. The
  // add weight is redrawn every twenty beats so the queue grows and shrinks.
  task automatic test_random_traffic(int n_items);
    int              add_pct;
    int              roll;
    logic [SLOT_W:0] pick;
    add_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) add_pct = $urandom_range(25, 70);
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
        pick = ($urandom_range(0, 9) != 0) ? find_slot(1'b0) : NO_ENTRY;
        if (pick == NO_ENTRY) pick = {1'b0, rand_slot()};
        send_cmd(wqe_pkg::CMD_ADD, pick[SLOT_W-1:0], rand_task());
      end else if (roll < add_pct + (100 - add_pct) / 2) begin
        pick = ($urandom_range(0, 9) != 0) ? find_slot(1'b1) : NO_ENTRY;
        if (pick == NO_ENTRY) pick = {1'b0, rand_slot()};
        send_cmd(wqe_pkg::CMD_REMOVE, pick[SLOT_W-1:0], rand_task());
      end else if (roll < add_pct + 3 * (100 - add_pct) / 4) begin
        send_cmd(wqe_pkg::CMD_WAKE_ONE, rand_slot(), rand_task());
      end else begin
        send_cmd(wqe_pkg::CMD_WAKE_ALL, rand_slot(), rand_task());
      end
    end
  endtask

  // Empties the queue, then holds the receiver off while every slot is linked,
  // so the engine backs up and stalls its input. A wake all on the full queue
  // then reaches the wake limit.
  task automatic test_full_queue_under_stall();
    logic [SLOT_W:0] pick;
    pick = find_slot(1'b1);
    while (pick != NO_ENTRY) begin
      send_cmd(wqe_pkg::CMD_REMOVE, pick[SLOT_W-1:0], rand_task());
      pick = find_slot(1'b1);
    end
    stall_req <= stall_req + 1;
    pick = find_slot(1'b0);
    while (pick != NO_ENTRY) begin
      send_cmd(wqe_pkg::CMD_ADD, pick[SLOT_W-1:0], rand_task());
      pick = find_slot(1'b0);
    end
    send_cmd(wqe_pkg::CMD_WAKE_ALL, rand_slot(), rand_task());
    send_cmd(wqe_pkg::CMD_WAKE_ONE, rand_slot(), rand_task());
    send_cmd(wqe_pkg::CMD_ADD, rand_slot(), rand_task());
    send_cmd(wqe_pkg::CMD_WAKE_ALL, rand_slot(), rand_task());
  endtask

  initial begin
    // The engine clears its marks and head at reset, so the scoreboard starts
    // from an empty queue too.
    head_slot = NO_ENTRY;
    for (int s = 0; s < SLOTS_DEF; s++) begin
      linked_flag[s] = 1'b0;
      older_link[s]  = NO_ENTRY;
      newer_link[s]  = NO_ENTRY;
      waiter_task[s] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: a slow sender and a very slow receiver.
    send_idle_pct = 27;
    recv_idle_pct = 69;
    test_directed_basics();
    test_random_traffic(25);

    // Second phase: the other way round.
    send_idle_pct = 69;
    recv_idle_pct = 27;
    test_random_traffic(25);

    // Third phase: both sides at full rate, then the hold-off test.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(25);
    test_full_queue_under_stall();
    in_valid <= 1'b0;

    while (queue_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including the long hold-off and full
  // wake-all bursts under heavy receiver idling.
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== wait_queue_engine_unit.f =====
+incdir+design
design/wqe_pkg.sv
design/wqe_table.sv
design/wait_queue_engine_unit.sv
tb/sv/tb_wait_queue_engine_unit.sv
